@@ hdl/assert_macros.svh @@
// Assertion macros shared by the ring buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

`endif

@@ hdl/orbavg_pkg.sv @@
// Shared types, constants and helpers for the averaging ring buffer.
`default_nettype none

package orbavg_pkg;

  localparam int DATA_W            = 32;
  localparam int CNT_W             = 7;
  localparam int CNT_MAX           = (1 << CNT_W) - 1;
  localparam int ETYPE_W           = 2;
  localparam int CFG_ADDR_W        = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int DEFAULT_MAX_DEPTH = 64;
  localparam int DEPTH_RESET       = 64;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_DEPTH = 1'b0;
  localparam logic REG_ETYPE = 1'b1;

  // Element type codes
  localparam logic [ETYPE_W-1:0] ETYPE_S8  = 2'd0;
  localparam logic [ETYPE_W-1:0] ETYPE_S16 = 2'd1;
  localparam logic [ETYPE_W-1:0] ETYPE_S32 = 2'd2;

  // Opcodes carried in s_tuser
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]   depth;
    logic [ETYPE_W-1:0] etype;
    logic               clear;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Keep the low bits that the element type selects and sign-extend them.
  function automatic logic [DATA_W-1:0] widen(input logic [DATA_W-1:0] raw,
                                              input logic [ETYPE_W-1:0] et);
    logic [DATA_W-1:0] v;
    case (et)
      ETYPE_S16: v = {{(DATA_W-16){raw[15]}}, raw[15:0]};
      ETYPE_S32: v = raw;
      default:   v = {{(DATA_W-8){raw[7]}}, raw[7:0]};
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/orbavg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module orbavg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/orbavg_cfg.sv @@
// APB register block: ring depth and element type.
`default_nettype none

module orbavg_cfg import orbavg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic [CNT_W-1:0]   depth;
  logic [ETYPE_W-1:0] etype;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= CNT_W'(DEPTH_RESET);
      etype <= ETYPE_S8;
    end else if (wr) begin
      case (paddr[2])
        REG_DEPTH: depth <= pwdata[CNT_W-1:0];
        REG_ETYPE: etype <= pwdata[ETYPE_W-1:0];
        default:   depth <= depth;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEPTH: prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, depth};
      REG_ETYPE: prdata = {{(CFG_DATA_W-ETYPE_W){1'b0}}, etype};
      default:   prdata = '0;
    endcase
  end

  // Either register write empties the ring
  assign cfg.depth = depth;
  assign cfg.etype = etype;
  assign cfg.clear = wr;

endmodule

`default_nettype wire

@@ hdl/orbavg_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none

`include "assert_macros.svh"

module orbavg_div import orbavg_pkg::*; #(
  parameter int DIVIDEND_W = 38,
  parameter int DIVISOR_W  = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output div_status_t                status,
  output logic      [DIVIDEND_W-1:0] quotient
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvsr;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic                 done;
  logic [DIVISOR_W:0]   trial;
  logic                 ge;
  logic [DIVISOR_W:0]   diff;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dvsr};
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvsr     <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIVIDEND_W-2:0], ge};
      rem      <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;

  `ASSERT_IMPLY(a_div_nonzero, start, divisor != '0, "divider started with zero divisor")
  `ASSERT_IMPLY(a_div_rem, busy, rem < dvsr, "partial remainder not below divisor")
  `ASSERT_IMPLY(a_div_start_idle, start, !busy, "divider restarted while busy")

endmodule

`default_nettype wire

@@ hdl/overwriting_ring_buffer_with_average.sv @@
// Ring buffer that overwrites its oldest sample when full and reports the mean.
// Each accepted beat passes through read, subtract, add and launch steps, then the
//   bit-serial divide (skipped when the ring ends up empty) and the output register.
// The block takes no new beat until it is through with the last one, including the divide;
//   s_tready is high only while the sequencer idles.
// Reset: empties the ring, clears the last popped value, depth 64, 8-bit samples.
`default_nettype none

`include "assert_macros.svh"

module overwriting_ring_buffer_with_average import orbavg_pkg::*; #(
  parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // s_tdata: sample[31:0]
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [DATA_W-1:0]     s_tdata,
  // s_tuser: opcode[0] (0 push, 1 pop)
  input  wire logic [0:0]            s_tuser,
  // m_tdata: popped_value[31:0], fill_count[38:32], mean_value[70:39], zero pad[71]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [71:0]                m_tdata,
  // m_tuser: popped_valid[0], dropped_oldest[1]
  output logic [1:0]                 m_tuser,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int AW       = $clog2(MAX_DEPTH);
  localparam int SUM_W    = DATA_W + AW;
  localparam int DepthCap = (MAX_DEPTH > CNT_MAX) ? CNT_MAX : MAX_DEPTH;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_SUB    = 7'b0000100,
    S_ADD    = 7'b0001000,
    S_LAUNCH = 7'b0010000,
    S_DIVIDE = 7'b0100000,
    S_HOLD   = 7'b1000000
  } state_t;

  state_t state, state_next;

  cfg_t              cfg;
  logic [CNT_W-1:0]  live;

  logic              op;
  logic [DATA_W-1:0] smp;
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic [DATA_W-1:0] last_popped;

  logic [DATA_W-1:0] res_popped;
  logic              res_valid;
  logic              res_dropped;
  logic              div_neg;

  logic [DATA_W-1:0] out_popped;
  logic              out_valid_flag;
  logic              out_dropped;
  logic [CNT_W-1:0]  out_count;
  logic [DATA_W-1:0] out_mean;

  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              full;
  logic [SUM_W-1:0]  rd_ext;
  logic [SUM_W-1:0]  smp_ext;
  logic [SUM_W-1:0]  sum_abs;
  logic [DATA_W-1:0] quo_low;
  logic [DATA_W-1:0] mean;
  logic              out_free;

  logic              div_start;
  div_status_t       div_status;
  logic [SUM_W-1:0]  div_quotient;

  // Advance a ring index, wrapping at the live depth.
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx,
                                               input logic [CNT_W-1:0] lim);
    logic [AW:0] inc;
    inc = {1'b0, idx} + 1'b1;
    return (32'(inc) >= 32'(lim)) ? '0 : inc[AW-1:0];
  endfunction

  orbavg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Depth 0 acts as 1; anything above the store size is capped.
  always_comb begin
    if (cfg.depth == '0) begin
      live = CNT_W'(1);
    end else if (32'(cfg.depth) > DepthCap) begin
      live = CNT_W'(DepthCap);
    end else begin
      live = cfg.depth;
    end
  end

  // Sample store: read head for a pop, tail for a push (equal to head when full)
  assign ram_raddr = (op == OP_POP) ? head : tail;
  assign ram_we    = (state == S_SUB) && (op == OP_PUSH);

  orbavg_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (smp),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign full    = count >= live;
  assign rd_ext  = {{(SUM_W-DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata};
  assign smp_ext = {{(SUM_W-DATA_W){smp[DATA_W-1]}}, smp};
  assign sum_abs = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;

  assign div_start = (state == S_LAUNCH) && (count != '0);

  orbavg_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_abs),
    .divisor  (count),
    .status   (div_status),
    .quotient (div_quotient)
  );

  // The mean always fits a sample, so the low word carries it; restore the sign
  assign quo_low  = div_quotient[DATA_W-1:0];
  assign mean     = (count == '0) ? '0 : (div_neg ? (DATA_W'(0) - quo_low) : quo_low);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_tvalid) state_next = S_READ;
      S_READ:   state_next = S_SUB;
      S_SUB:    state_next = S_ADD;
      S_ADD:    state_next = S_LAUNCH;
      S_LAUNCH: state_next = (count == '0) ? S_HOLD : S_DIVIDE;
      S_DIVIDE: if (div_status.done) state_next = S_HOLD;
      S_HOLD:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  // Sequencer and ring control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      sum         <= '0;
      last_popped <= '0;
    end else begin
      state <= state_next;
      if (cfg.clear) begin
        // Empty the ring; the last popped value survives
        head  <= '0;
        tail  <= '0;
        count <= '0;
        sum   <= '0;
      end else if (state == S_SUB) begin
        if (op == OP_PUSH) begin
          if (full) begin
            // Overwrite the oldest sample: drop it from the sum, move the head
            sum  <= sum - rd_ext;
            head <= next_slot(head, live);
          end else begin
            count <= count + 1'b1;
          end
          tail <= next_slot(tail, live);
        end else if (count != '0) begin
          sum         <= sum - rd_ext;
          last_popped <= ram_rdata;
          head        <= next_slot(head, live);
          count       <= count - 1'b1;
        end
      end else if (state == S_ADD && op == OP_PUSH) begin
        sum <= sum + smp_ext;
      end
    end
  end

  // Beat payload and per-step results
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op  <= s_tuser[0];
      smp <= widen(s_tdata, cfg.etype);
    end
    if (state == S_SUB) begin
      if (op == OP_PUSH) begin
        res_popped  <= '0;
        res_valid   <= 1'b0;
        res_dropped <= full;
      end else begin
        res_popped  <= (count != '0) ? ram_rdata : last_popped;
        res_valid   <= (count != '0);
        res_dropped <= 1'b0;
      end
    end
    if (state == S_LAUNCH) begin
      div_neg <= sum[SUM_W-1];
    end
  end

  // Output register: hold a result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_HOLD && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HOLD && out_free) begin
      out_popped     <= res_popped;
      out_valid_flag <= res_valid;
      out_dropped    <= res_dropped;
      out_count      <= count;
      out_mean       <= mean;
    end
  end

  assign m_tdata = {1'b0, out_mean, out_count, out_popped};
  assign m_tuser = {out_dropped, out_valid_flag};

  `ASSERT_CLK(a_count_bound, count <= live, "held count exceeds live depth")
  `ASSERT_IMPLY(a_empty_sum, count == '0, sum == '0, "empty ring with nonzero sum")
  `ASSERT_IMPLY(a_ring_edges, (count == '0) || (count == live), head == tail,
                "head and tail disagree on an empty or full ring")
  `ASSERT_IMPLY(a_div_done_state, div_status.done, state == S_DIVIDE,
                "divider finished outside the divide state")

endmodule

`default_nettype wire

@@ sim/overwriting_ring_buffer_with_average_tb.sv @@
// Self-checking testbench for the overwriting ring buffer with running mean.
`default_nettype none

module overwriting_ring_buffer_with_average_tb;
  import orbavg_pkg::*;

  localparam int RING_SLOTS = DEFAULT_MAX_DEPTH;
  // Element type code with no width of its own; the block treats it as 8 bit
  localparam logic [ETYPE_W-1:0] ETYPE_RSVD = 2'd3;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    logic        op;
    logic [31:0] sample;
  } ring_op_t;

  typedef struct {
    logic [31:0] popped_value;
    logic        popped_valid;
    logic        dropped_oldest;
    logic [6:0]  fill_count;
    logic [31:0] mean_value;
  } ring_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata = '0;
  logic [0:0]            s_tuser = OP_PUSH;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [71:0]           m_tdata;
  logic [1:0]            m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  overwriting_ring_buffer_with_average dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the ring, its sum and its registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] ring_store [0:RING_SLOTS-1];
  logic [5:0]         head_slot = '0;
  logic [5:0]         tail_slot = '0;
  int unsigned        ring_fill = 0;
  longint             ring_sum = 0;
  logic [31:0]        last_taken = '0;
  logic [6:0]         cfg_depth = 7'(DEPTH_RESET);
  logic [ETYPE_W-1:0] cfg_etype = ETYPE_S8;

  ring_op_t      queued_ops [$];
  ring_outcome_t ring_outcomes [$];
  int            ops_queued = 0;
  int            ops_taken = 0;
  int            results_seen = 0;
  int            mismatches = 0;

  // Pacing knobs, set per phase by the stimulus
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  bit hold_off_req = 1'b0;
  int gap_left = 0;
  int hold_left = 0;
  bit beat_taken = 1'b0;

  // Slots actually in use: a depth of zero acts as one, oversize clamps to the max
  function automatic int unsigned ring_span();
    if (cfg_depth == 0) return 1;
    if (cfg_depth > RING_SLOTS) return RING_SLOTS;
    return cfg_depth;
  endfunction

  function automatic logic [5:0] step_slot(input logic [5:0] idx);
    int unsigned n;
    n = idx + 1;
    return (n >= ring_span()) ? 6'd0 : 6'(n);
  endfunction

  // Keep the low 8, 16 or 32 bits per element type and sign-extend them
  function automatic logic signed [31:0] extend_sample(input logic [31:0] raw);
    case (cfg_etype)
      ETYPE_S16: return {{16{raw[15]}}, raw[15:0]};
      ETYPE_S32: return raw;
      default:   return {{24{raw[7]}}, raw[7:0]};
    endcase
  endfunction

  // Apply one beat to the predicted ring and form the result it must produce
  function automatic ring_outcome_t advance_ring(input logic op, input logic [31:0] raw);
    ring_outcome_t      o;
    logic signed [31:0] s;
    longint             mean_q;
    o.popped_value   = '0;
    o.popped_valid   = 1'b0;
    o.dropped_oldest = 1'b0;
    if (op == OP_PUSH) begin
      s = extend_sample(raw);
      if (ring_fill >= ring_span()) begin
        // Full: the oldest sample sits where the tail points; retire it
        ring_sum -= ring_store[tail_slot];
        head_slot = step_slot(head_slot);
        o.dropped_oldest = 1'b1;
      end else begin
        ring_fill++;
      end
      ring_store[tail_slot] = s;
      ring_sum += s;
      tail_slot = step_slot(tail_slot);
    end else begin
      if (ring_fill > 0) begin
        s = ring_store[head_slot];
        ring_sum -= s;
        last_taken = s;
        head_slot = step_slot(head_slot);
        ring_fill--;
        o.popped_valid = 1'b1;
      end
      // An empty pop repeats whatever was last taken out
      o.popped_value = last_taken;
    end
    o.fill_count = 7'(ring_fill);
    if (ring_fill > 0) begin
      // Signed division truncates toward zero, as the mean must
      mean_q = ring_sum / longint'(ring_fill);
      o.mean_value = mean_q[31:0];
    end else begin
      o.mean_value = '0;
    end
    return o;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at result %0d: %s got %0h want %0h", results_seen, field, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Input side: take accepted beats at the rising edge, offer new ones at the
  // falling edge. Hold a beat steady until the block takes it.
  // ---------------------------------------------------------------------------
  function automatic int sender_gap();
    int r;
    if (!tx_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(30, 120);
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      ring_outcomes.push_back(advance_ring(s_tuser[0], s_tdata));
      ops_taken++;
      beat_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : feed_ops
    ring_op_t nxt;
    if (!rst && (!s_tvalid || beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (queued_ops.size() != 0) begin
        nxt = queued_ops.pop_front();
        s_tdata  <= nxt.sample;
        s_tuser  <= nxt.op;
        s_tvalid <= 1'b1;
        gap_left = sender_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: pace m_tready, check every accepted result beat
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : pace_results
    int r;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_off_req) begin
      // Long hold-off: stall the result side so the block backs up its input
      hold_off_req = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else if (!rx_gaps) begin
      m_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        hold_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 90);
      end
    end
  end

  always @(posedge clk) begin : check_results
    ring_outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (ring_outcomes.size() == 0) begin
        report_mismatch("result with nothing outstanding", m_tdata[63:0], 64'd0);
      end else begin
        want = ring_outcomes.pop_front();
        // m_tdata: popped_value[31:0], fill_count[38:32], mean_value[70:39]
        if (m_tdata[31:0] !== want.popped_value)
          report_mismatch("popped_value", m_tdata[31:0], want.popped_value);
        if (m_tdata[38:32] !== want.fill_count)
          report_mismatch("fill_count", m_tdata[38:32], want.fill_count);
        if (m_tdata[70:39] !== want.mean_value)
          report_mismatch("mean_value", m_tdata[70:39], want.mean_value);
        // m_tuser: popped_valid[0], dropped_oldest[1]
        if (m_tuser[0] !== want.popped_valid)
          report_mismatch("popped_valid", m_tuser[0], want.popped_valid);
        if (m_tuser[1] !== want.dropped_oldest)
          report_mismatch("dropped_oldest", m_tuser[1], want.dropped_oldest);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_op(input logic op, input logic [31:0] sample);
    ring_op_t b;
    b.op = op;
    b.sample = sample;
    queued_ops.push_back(b);
    ops_queued++;
  endtask

  // Wait until every beat is taken, every result checked and the block idles
  task automatic settle();
    while (ops_taken != ops_queued || ring_outcomes.size() != 0 || !s_tready)
      @(posedge clk);
  endtask

  // Write a register through the config port, mirror it, then read it back
  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    logic [CFG_ADDR_W-1:0] addr;
    logic [31:0]           want;
    addr = '0;
    addr[2] = reg_sel;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // Any register write empties the ring but keeps the last popped value
    if (reg_sel == REG_DEPTH) begin
      cfg_depth = value[6:0];
      want = {25'b0, value[6:0]};
    end else begin
      cfg_etype = value[ETYPE_W-1:0];
      want = 32'(value[ETYPE_W-1:0]);
    end
    head_slot = '0;
    tail_slot = '0;
    ring_fill = 0;
    ring_sum  = 0;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Draw a sample: the width's extremes, zero, minus one or anything, with
  // random bits above the used width so every input bit toggles
  function automatic logic [31:0] pick_sample(input int flavor);
    logic [31:0] r, mask, top;
    r = $urandom;
    case (cfg_etype)
      ETYPE_S16: begin mask = 32'h0000_FFFF; top = 32'h0000_7FFF; end
      ETYPE_S32: begin mask = 32'hFFFF_FFFF; top = 32'h7FFF_FFFF; end
      default:   begin mask = 32'h0000_00FF; top = 32'h0000_007F; end
    endcase
    if (flavor == 4) begin
      case ($urandom_range(0, 3))
        0:       return (r & ~mask) | top;
        1:       return (r & ~mask) | (top + 1);
        2:       return r & ~mask;
        default: return r | mask;
      endcase
    end
    case (flavor)
      0:       return (r & ~mask) | top;
      1:       return (r & ~mask) | (top + 1);
      default: return r;
    endcase
  endfunction

  // Runs of pushes and pops with a bias per run, so the ring fills, wraps,
  // overwrites and drains again; some runs stick to one extreme to push the
  // running sum to its limits
  task automatic queue_random_ops(input int n_ops);
    int left, run_len, push_pct, flavor, k;
    left = n_ops;
    while (left > 0) begin
      run_len = $urandom_range(1, 2 * ring_span() + 4);
      if (run_len > left) run_len = left;
      case ($urandom_range(0, 3))
        0:       push_pct = 20;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      flavor = $urandom_range(0, 4);
      for (k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 99) < push_pct) queue_op(OP_PUSH, pick_sample(flavor));
        else queue_op(OP_POP, $urandom);
      end
      left -= run_len;
    end
  endtask

  task automatic run_phase(input logic [6:0] depth, input logic [ETYPE_W-1:0] etype,
                           input int n_ops, input bit with_tx_gaps,
                           input bit with_rx_gaps, input bit with_hold_off);
    write_reg(REG_DEPTH, {25'b0, depth});
    write_reg(REG_ETYPE, 32'(etype));
    tx_gaps = with_tx_gaps;
    rx_gaps = with_rx_gaps;
    if (with_hold_off) hold_off_req = 1'b1;
    queue_random_ops(n_ops);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, reset config (64 slots, 8-bit samples): pop on an empty ring,
    // 8-bit extremes with junk above bit 7, then drain past empty
    queue_op(OP_POP, 32'h0);
    queue_op(OP_PUSH, 32'hABCD_EF7F);
    queue_op(OP_PUSH, 32'hFFFF_FF80);
    queue_op(OP_PUSH, 32'h1234_5600);
    queue_op(OP_PUSH, 32'h7FFF_FFFF);
    repeat (5) queue_op(OP_POP, 32'hFFFF_FFFF);
    settle();

    // Depth zero acts as one slot; 32-bit extremes overwrite each other
    write_reg(REG_DEPTH, 32'd0);
    write_reg(REG_ETYPE, 32'(ETYPE_S32));
    queue_op(OP_PUSH, 32'h7FFF_FFFF);
    queue_op(OP_PUSH, 32'h8000_0000);
    queue_op(OP_POP, 32'h0);
    queue_op(OP_POP, 32'h0);
    settle();

    // Oversize depth clamps; reserved type acts as 8 bit; last popped survives
    write_reg(REG_DEPTH, 32'd127);
    write_reg(REG_ETYPE, 32'(ETYPE_RSVD));
    queue_op(OP_POP, 32'h0);
    queue_op(OP_PUSH, 32'h0000_0081);
    queue_op(OP_POP, 32'h0);
    settle();

    // Two slots, 16-bit samples: fill, overwrite the oldest, drain
    write_reg(REG_DEPTH, 32'd2);
    write_reg(REG_ETYPE, 32'(ETYPE_S16));
    queue_op(OP_PUSH, 32'h0001_7FFF);
    queue_op(OP_PUSH, 32'hFFFF_8000);
    queue_op(OP_PUSH, 32'hABCD_8001);
    queue_op(OP_POP, 32'h0);
    queue_op(OP_POP, 32'h0);
    settle();

    // Random phases over the register extremes and a few in between
    run_phase(7'd1, ETYPE_S8, 205, 1'b1, 1'b1, 1'b0);
    run_phase(7'd64, ETYPE_S32, 205, 1'b0, 1'b0, 1'b1);
    run_phase(7'd0, ETYPE_RSVD, 205, 1'b1, 1'b0, 1'b0);
    run_phase(7'd127, ETYPE_S16, 205, 1'b0, 1'b1, 1'b0);
    run_phase(7'($urandom_range(3, 63)), ETYPE_S32, 205, 1'b1, 1'b1, 1'b0);
    run_phase(7'd2, ETYPE_S16, 205, 1'b1, 1'b1, 1'b0);
    run_phase(7'($urandom_range(3, 63)), ETYPE_S8, 205, 1'b1, 1'b1, 1'b1);
    run_phase(7'd64, ETYPE_S16, 205, 1'b1, 1'b1, 1'b0);

    // Let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && ring_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #16_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
